@@ design/fpe_pkg.sv @@
package fpe_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_PLANES = 6;
    localparam logic [2:0] PLANE_NEAR = 3'd4;
    localparam logic [2:0] PLANE_FAR = 3'd5;

    // One queued job: which planes to produce for the stored matrix.
    typedef struct packed {
        logic near_only;
    } t_job;

    // One plane's raw (unnormalized) coefficients with its tags.
    typedef struct packed {
        logic [2:0] plane;
        logic last;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [WORD_W-1:0] c;
        logic signed [WORD_W-1:0] d;
    } t_plane;

    function automatic logic signed [WORD_W-1:0] sat_add(
        input logic signed [WORD_W-1:0] x,
        input logic signed [WORD_W-1:0] y,
        input logic minus
    );
        logic signed [WORD_W:0] s;
        begin
            s = minus ? ({x[WORD_W-1], x} - {y[WORD_W-1], y})
                      : ({x[WORD_W-1], x} + {y[WORD_W-1], y});
            if (s[WORD_W] != s[WORD_W-1]) begin
                sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                    : {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                sat_add = s[WORD_W-1:0];
            end
        end
    endfunction

endpackage

@@ design/fpe_front.sv @@
// Matrix store and plane assembly; queues jobs for the normalizer.
module fpe_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic signed [fpe_pkg::WORD_W-1:0] i_value,
    input  logic [3:0] i_index,
    input  logic i_go,
    input  logic i_near_only,
    output logic o_busy,
    output logic o_plane_valid,
    output fpe_pkg::t_plane o_plane,
    input  logic i_plane_take
);
    logic signed [fpe_pkg::WORD_W-1:0] r_mat [16];
    // Two-entry job queue.
    fpe_pkg::t_job r_q [2];
    logic [1:0] r_q_cnt, n_q_cnt;
    logic r_q_rd, r_q_wr;
    logic [2:0] r_k;
    logic r_act;
    fpe_pkg::t_job r_job;

    logic push, pop;
    logic [1:0] row;
    logic minus;
    logic [2:0] plane;

    assign push = i_load && i_go;
    assign pop = (r_q_cnt != 2'd0) && !r_act;
    // Items are held off from the start item until the last plane has been
    // taken, so the store stays fixed while planes are built from it.
    assign o_busy = (r_q_cnt != 2'd0) || r_act;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat[i_index] <= i_value;
        end
        if (push) begin
            r_q[r_q_wr].near_only <= i_near_only;
        end
        if (pop) begin
            r_job <= r_q[r_q_rd];
        end
    end

    always_comb begin
        n_q_cnt = r_q_cnt;
        if (push && !pop) begin
            n_q_cnt = r_q_cnt + 2'd1;
        end else if (pop && !push) begin
            n_q_cnt = r_q_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
            r_q_rd <= 1'b0;
            r_q_wr <= 1'b0;
            r_act <= 1'b0;
            r_k <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (push) begin
                r_q_wr <= !r_q_wr;
            end
            if (pop) begin
                r_q_rd <= !r_q_rd;
                r_act <= 1'b1;
                r_k <= r_q[r_q_rd].near_only ? fpe_pkg::PLANE_NEAR : 3'd0;
            end else if (r_act && i_plane_take) begin
                if (r_job.near_only || r_k == fpe_pkg::PLANE_FAR) begin
                    r_act <= 1'b0;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
        end
    end

    // Each plane is built from the store at the moment the normalizer takes it.
    assign row = r_k[2:1];
    assign minus = r_k[0];
    assign plane = r_k;
    assign o_plane_valid = r_act;
    assign o_plane.plane = plane;
    assign o_plane.last = r_job.near_only || (r_k == fpe_pkg::PLANE_FAR);
    assign o_plane.a = fpe_pkg::sat_add(r_mat[12], r_mat[{row, 2'd0}], minus);
    assign o_plane.b = fpe_pkg::sat_add(r_mat[13], r_mat[{row, 2'd1}], minus);
    assign o_plane.c = fpe_pkg::sat_add(r_mat[14], r_mat[{row, 2'd2}], minus);
    assign o_plane.d = fpe_pkg::sat_add(r_mat[15], r_mat[{row, 2'd3}], minus);
endmodule

@@ design/fpe_back.sv @@
// Normalizer: squared length, bit-serial square root, four serial divisions.
module fpe_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_plane_valid,
    input  fpe_pkg::t_plane i_plane,
    output logic o_plane_take,
    output logic o_valid,
    output logic [2:0] o_plane_index,
    output logic signed [fpe_pkg::WORD_W-1:0] o_coef_a,
    output logic signed [fpe_pkg::WORD_W-1:0] o_coef_b,
    output logic signed [fpe_pkg::WORD_W-1:0] o_coef_c,
    output logic signed [fpe_pkg::WORD_W-1:0] o_coef_d,
    output logic o_degenerate,
    output logic o_final_plane
);
    localparam int NUM_W = 32 + FRAC_BITS + 1;
    localparam int QMAX = 41;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_ROOT = 6'b000100,
        S_DIV  = 6'b001000,
        S_NEXT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    fpe_pkg::t_plane r_p;
    logic [1:0] r_sel;
    logic [5:0] r_cnt;
    logic [65:0] r_sq;
    logic [65:0] r_rem;
    logic [32:0] r_root;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_drem;
    logic [NUM_W-1:0] r_quo;
    logic signed [fpe_pkg::WORD_W-1:0] r_res [4];
    logic r_out;

    logic signed [fpe_pkg::WORD_W-1:0] cur;
    logic [31:0] mag;
    logic [63:0] prod;
    logic [65:0] trial;
    logic [65:0] rem_sh;
    logic [NUM_W-1:0] d_sh;
    logic [NUM_W-1:0] lenx;
    logic [NUM_W-1:0] qsat;
    logic signed [fpe_pkg::WORD_W:0] sres;

    always_comb begin
        unique case (r_sel)
            2'd0: cur = r_p.a;
            2'd1: cur = r_p.b;
            2'd2: cur = r_p.c;
            default: cur = r_p.d;
        endcase
        mag = cur[31] ? 32'(-cur) : 32'(cur);
        prod = 64'(mag) * 64'(mag);
        rem_sh = {r_rem[63:0], r_sq[65:64]};
        trial = 66'({r_root[31:0], 2'b01});
        d_sh = {r_drem[NUM_W-2:0], r_num[NUM_W-1]};
        lenx = NUM_W'(r_root);
        qsat = (r_quo > NUM_W'(64'd1 << QMAX-1)) ? NUM_W'(64'd1 << QMAX-1) : r_quo;
        if (cur[31]) begin
            sres = -$signed({1'b0, qsat[31:0]});
            if (qsat[NUM_W-1:31] != '0 && !(qsat == NUM_W'(64'h80000000))) begin
                sres = {1'b1, 1'b1, 31'd0};
            end
        end else begin
            sres = $signed({1'b0, qsat[31:0]});
            if (qsat[NUM_W-1:31] != '0) begin
                sres = {2'b00, {31{1'b1}}};
            end
        end
    end

    assign o_plane_take = (r_state == S_IDLE) && i_plane_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out <= 1'b0;
        end else begin
            r_out <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_plane_valid) begin
                        r_p <= i_plane;
                        r_sel <= 2'd0;
                        r_sq <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq <= r_sq + 66'(prod);
                    if (r_sel == 2'd2) begin
                        r_sel <= 2'd0;
                        r_cnt <= 6'd0;
                        r_rem <= '0;
                        r_root <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_sel <= r_sel + 2'd1;
                    end
                end
                S_ROOT: begin
                    r_sq <= {r_sq[63:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem <= rem_sh - trial;
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    if (r_cnt == 6'd32) begin
                        r_state <= S_NEXT;
                        r_sel <= 2'd0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_NEXT: begin
                    if (r_root == '0) begin
                        r_state <= S_OUT;
                        r_out <= 1'b1;
                    end else begin
                        r_num <= (NUM_W'(mag) << FRAC_BITS) + (lenx >> 1);
                        r_drem <= '0;
                        r_quo <= '0;
                        r_cnt <= 6'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    if (d_sh >= lenx) begin
                        r_drem <= d_sh - lenx;
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_drem <= d_sh;
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'(NUM_W)) begin
                        r_res[r_sel] <= sres[31:0];
                        if (r_sel == 2'd3) begin
                            r_state <= S_OUT;
                            r_out <= 1'b1;
                        end else begin
                            r_sel <= r_sel + 2'd1;
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The division's last cycle stores the quotient as it stood before that cycle's
    // shift, so the final shift does not reach the stored result.
    assign o_valid = r_out;
    assign o_plane_index = r_p.plane;
    assign o_degenerate = (r_root == '0);
    assign o_coef_a = o_degenerate ? '0 : r_res[0];
    assign o_coef_b = o_degenerate ? '0 : r_res[1];
    assign o_coef_c = o_degenerate ? '0 : r_res[2];
    assign o_coef_d = o_degenerate ? '0 : r_res[3];
    assign o_final_plane = r_p.last;
endmodule

@@ design/frustum_plane_extractor.sv @@
// From the edge that takes the start item, the planes (all six, or the near plane only
// in near-only mode) pass one at a time through squaring of a, b and c, the bit-serial
// root and four serial divisions; a degenerate plane skips the divisions.
// Busy holds off items from the start item until the last plane enters the normalizer;
// other items are taken one per cycle. Results cannot be stalled.
// Reset clears control state and the mode register; the matrix store is not cleared.
module frustum_plane_extractor #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [31:0] i_element_value,
    input  logic [3:0] i_element_index,
    input  logic i_start_compute,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_near_only_mode,
    output logic o_valid,
    output logic [2:0] o_plane_index,
    output logic signed [31:0] o_coef_a,
    output logic signed [31:0] o_coef_b,
    output logic signed [31:0] o_coef_c,
    output logic signed [31:0] o_coef_d,
    output logic o_degenerate,
    output logic o_final_plane
);
    logic r_near_only;
    logic load, pv, take;
    fpe_pkg::t_plane plane;

    assign o_cfg_ready = 1'b1;
    assign load = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_only <= 1'b0;
        end else if (i_cfg_valid) begin
            r_near_only <= i_cfg_near_only_mode;
        end
    end

    fpe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load),
        .i_value(i_element_value), .i_index(i_element_index),
        .i_go(i_start_compute), .i_near_only(r_near_only),
        .o_busy(busy), .o_plane_valid(pv), .o_plane(plane),
        .i_plane_take(take)
    );

    fpe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_plane_valid(pv),
        .i_plane(plane), .o_plane_take(take), .o_valid(o_valid),
        .o_plane_index(o_plane_index), .o_coef_a(o_coef_a),
        .o_coef_b(o_coef_b), .o_coef_c(o_coef_c), .o_coef_d(o_coef_d),
        .o_degenerate(o_degenerate), .o_final_plane(o_final_plane)
    );

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_coef_a == 0 && o_coef_d == 0))
        else $error("degenerate plane with nonzero coefficients");
    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_plane_index <= 3'd5))
        else $error("plane index out of range");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");
endmodule

@@ test/frustum_plane_checker.sv @@
`timescale 1ns / 100ps

module frustum_plane_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  logic signed [31:0] i_element_value,
    input  logic [3:0] i_element_index,
    input  logic i_start_compute,
    input  logic i_cfg_valid,
    input  logic o_cfg_ready,
    input  logic i_cfg_near_only_mode,
    input  logic o_valid,
    input  logic [2:0] o_plane_index,
    input  logic signed [31:0] o_coef_a,
    input  logic signed [31:0] o_coef_b,
    input  logic signed [31:0] o_coef_c,
    input  logic signed [31:0] o_coef_d,
    input  logic o_degenerate,
    input  logic o_final_plane,
    output int fail_count,
    output int planes_pending
);
    localparam int FRAC = 16;

    typedef struct {
        logic [2:0] plane;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic degen;
        logic last;
    } t_exp_plane;

    logic signed [31:0] matrix [16];
    logic near_only;
    t_exp_plane expected_planes[$];

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] normalize(longint v, logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        longint s;
        m = (v < 0) ? -v : v;
        q = ((m << FRAC) + (len >> 1)) / len;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        s = (v < 0) ? -longint'(q) : longint'(q);
        return 32'(clamp32(s));
    endfunction

    function automatic t_exp_plane clip_plane(int which, logic last);
        t_exp_plane p;
        longint coef [4];
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] m;
        sq = 0;
        for (int i = 0; i < 4; i++) begin
            if (which & 1)
                coef[i] = clamp32(longint'(matrix[12+i])
                                  - longint'(matrix[(which>>1)*4+i]));
            else
                coef[i] = clamp32(longint'(matrix[12+i])
                                  + longint'(matrix[(which>>1)*4+i]));
        end
        for (int i = 0; i < 3; i++) begin
            m = (coef[i] < 0) ? -coef[i] : coef[i];
            sq = sq + m * m;
        end
        len = root_floor(sq);
        p.plane = which[2:0];
        p.last = last;
        p.degen = (len == 0);
        if (len == 0) begin
            p.a = 0; p.b = 0; p.c = 0; p.d = 0;
        end else begin
            p.a = normalize(coef[0], len);
            p.b = normalize(coef[1], len);
            p.c = normalize(coef[2], len);
            p.d = normalize(coef[3], len);
        end
        return p;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_exp_plane e;
        if (!i_rst_n) begin
            near_only = 1'b0;
            fail_count = 0;
            expected_planes.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) near_only = i_cfg_near_only_mode;
            if (start && !busy) begin
                matrix[i_element_index] = i_element_value;
                if (i_start_compute) begin
                    if (near_only) begin
                        expected_planes.push_back(clip_plane(fpe_pkg::PLANE_NEAR, 1'b1));
                    end else begin
                        for (int k = 0; k < fpe_pkg::NUM_PLANES; k++)
                            expected_planes.push_back(
                                clip_plane(k, k == fpe_pkg::NUM_PLANES - 1));
                    end
                end
            end
            if (o_valid) begin
                if (expected_planes.size() == 0) begin
                    report_mismatch("plane with none expected");
                end else begin
                    e = expected_planes.pop_front();
                    if (o_plane_index !== e.plane)
                        report_mismatch($sformatf("plane_index %0d exp %0d",
                                                  o_plane_index, e.plane));
                    if (o_coef_a !== e.a)
                        report_mismatch($sformatf("plane %0d a %0d exp %0d",
                                                  e.plane, o_coef_a, e.a));
                    if (o_coef_b !== e.b)
                        report_mismatch($sformatf("plane %0d b %0d exp %0d",
                                                  e.plane, o_coef_b, e.b));
                    if (o_coef_c !== e.c)
                        report_mismatch($sformatf("plane %0d c %0d exp %0d",
                                                  e.plane, o_coef_c, e.c));
                    if (o_coef_d !== e.d)
                        report_mismatch($sformatf("plane %0d d %0d exp %0d",
                                                  e.plane, o_coef_d, e.d));
                    if (o_degenerate !== e.degen)
                        report_mismatch($sformatf("plane %0d degenerate %0b",
                                                  e.plane, o_degenerate));
                    if (o_final_plane !== e.last)
                        report_mismatch($sformatf("plane %0d final %0b",
                                                  e.plane, o_final_plane));
                end
            end
        end
        planes_pending = expected_planes.size();
    end

endmodule

@@ test/frustum_plane_extractor_test.sv @@
`timescale 1ns / 100ps

module frustum_plane_extractor_test;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [31:0] i_element_value;
    logic [3:0] i_element_index;
    logic i_start_compute;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_near_only_mode;
    logic o_valid;
    logic [2:0] o_plane_index;
    logic signed [31:0] o_coef_a;
    logic signed [31:0] o_coef_b;
    logic signed [31:0] o_coef_c;
    logic signed [31:0] o_coef_d;
    logic o_degenerate;
    logic o_final_plane;
    int fail_count;
    int planes_pending;
    int idle_cycles = 0;
    int burst_left;

    frustum_plane_extractor dut (.*);
    frustum_plane_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: counts cycles with no accepted load, config or plane.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Busy only changes at rising edges, so its value at the falling edge
    // tells whether the next rising edge takes the item.
    task automatic load_element(logic signed [31:0] value, logic [3:0] idx, logic go);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        start = 1'b1;
        i_element_value = value;
        i_element_index = idx;
        i_start_compute = go;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        start = 1'b0;
        i_start_compute = 1'b0;
    endtask

    task automatic drain();
        while (planes_pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_mode(logic mode);
        i_cfg_valid = 1'b1;
        i_cfg_near_only_mode = mode;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_value(int kind);
        unique case (kind)
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return 0;
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    // Writes all sixteen entries in random order, the last one starting the computation.
    task automatic load_matrix(int kind);
        int order [16];
        int j;
        int t;
        for (int i = 0; i < 16; i++) order[i] = i;
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i < 16; i++)
            load_element(kind < 0 ? rand_value($urandom_range(0, 6)) : rand_value(kind),
                         order[i][3:0], i == 15);
    endtask

    initial begin
        start = 1'b0;
        i_element_value = 0;
        i_element_index = 0;
        i_start_compute = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_near_only_mode = 1'b0;
        burst_left = 0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: identity-like, extremes, all-zero, then near-only all-max and all-min.
        for (int i = 0; i < 16; i++)
            load_element((i % 5 == 0) ? 32'sh10000 : 0, i[3:0], i == 15);
        load_element(32'sh7fffffff, 4'd0, 1'b0);
        load_element(32'sh80000000, 4'd12, 1'b0);
        load_element(32'sh80000000, 4'd15, 1'b1);
        drain();
        load_matrix(3);
        drain();
        set_mode(1'b1);
        load_matrix(1);
        drain();
        load_matrix(2);
        drain();
        set_mode(1'b0);

        for (int m = 0; m < 5; m++) begin
            load_matrix(-1);
            // A few extra writes over a complete store, then a restart.
            repeat ($urandom_range(0, 3))
                load_element(rand_value($urandom_range(0, 6)),
                             4'($urandom_range(0, 15)), 1'b0);
            load_element(rand_value(4), 4'($urandom_range(0, 15)), 1'b1);
            drain();
            set_mode(1'($urandom_range(0, 1)));
        end
        load_matrix(4);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/fpe_pkg.sv
design/fpe_front.sv
design/fpe_back.sv
design/frustum_plane_extractor.sv
test/frustum_plane_checker.sv
test/frustum_plane_extractor_test.sv
